/* hdl/etds_pkg.sv */
// Shared constants, codes and control/status types for the earliest-deadline timer set.
package etds_pkg;

    localparam int TIMER_COUNT = 16;
    localparam int ID_W        = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int DL_W        = 47;
    localparam int TIME_W      = 48;
    localparam int FID_W       = 4;

    typedef enum logic [1:0] {
        MODE_SET      = 2'd0,
        MODE_UNSET    = 2'd1,
        MODE_DISPATCH = 2'd2,
        MODE_WAIT     = 2'd3
    } mode_t;

    typedef struct packed {
        logic capture;   // input beat taken: latch operands, apply set/unset
        logic scan_en;   // issue one deadline read
        logic load;      // write result into output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_op;   // incoming beat needs a scan (dispatch or wait)
        logic scan_last; // read of the last entry is being issued
        logic out_free;  // output register can take a result this cycle
    } ctrl_status_t;

endpackage

/* hdl/etds_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module etds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/etds_ctrl.sv */
// Controller state machine: sequences capture, deadline scan and result load.
module etds_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  etds_pkg::ctrl_status_t status,
    output etds_pkg::ctrl_cmd_t    cmd
);
    import etds_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.scan_op ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign cmd.capture = in_valid && (state_reg == S_IDLE);
    assign cmd.scan_en = (state_reg == S_SCAN);
    assign cmd.load    = (state_reg == S_FINISH) && status.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/etds_dp.sv */
// Datapath: armed bits, deadline RAM, minimum scan and output register.
module etds_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  etds_pkg::ctrl_cmd_t               cmd,
    output etds_pkg::ctrl_status_t            status,
    input  etds_pkg::mode_t                   mode,
    input  logic [3:0]                        timer_id,
    input  logic signed [etds_pkg::TIME_W-1:0] expiry_time,
    input  logic [etds_pkg::DL_W-1:0]         now_time,
    input  logic signed [etds_pkg::TIME_W-1:0] wait_cap,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              fired,
    output logic [etds_pkg::FID_W-1:0]        fired_id,
    output logic signed [etds_pkg::TIME_W-1:0] wait_interval
);
    import etds_pkg::*;

    localparam logic [ID_W-1:0] LAST_IDX = ID_W'(TIMER_COUNT - 1);

    // operands held for the whole operation
    mode_t                    mode_reg;
    logic [DL_W-1:0]          now_reg;
    logic signed [TIME_W-1:0] maxw_reg;

    logic [TIMER_COUNT-1:0] armed_reg;

    // scan
    logic [ID_W-1:0] scan_cnt_reg;
    logic            rd_valid_reg;
    logic [ID_W-1:0] rd_idx_reg;
    logic [DL_W-1:0] ram_rdata;
    logic            best_valid_reg;
    logic [ID_W-1:0] best_idx_reg;
    logic [DL_W-1:0] best_dl_reg;
    logic            take;

    // output register
    logic                     out_valid_reg;
    logic                     fired_reg;
    logic [FID_W-1:0]         fired_id_reg;
    logic signed [TIME_W-1:0] wait_reg;

    logic [ID_W-1:0]          id_idx;
    logic                     id_ok;
    logic                     arm_new;
    logic                     ram_we;
    logic                     due;
    logic signed [TIME_W-1:0] top;
    logic signed [TIME_W-1:0] wait_val;

    assign id_idx  = ID_W'(timer_id);
    assign id_ok   = (int'(timer_id) < TIMER_COUNT);
    assign arm_new = (mode == MODE_SET) && !expiry_time[TIME_W-1];
    assign ram_we  = cmd.capture && id_ok && arm_new;

    etds_ram #(
        .WIDTH (DL_W),
        .DEPTH (TIMER_COUNT)
    ) u_deadline_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (id_idx),
        .wdata (expiry_time[DL_W-1:0]),
        .raddr (scan_cnt_reg),
        .rdata (ram_rdata)
    );

    assign take = rd_valid_reg && armed_reg[rd_idx_reg]
                  && (!best_valid_reg || (ram_rdata < best_dl_reg));

    assign due      = best_valid_reg && (best_dl_reg <= now_reg);
    assign top      = $signed({1'b0, best_dl_reg}) - $signed({1'b0, now_reg});
    assign wait_val = (best_valid_reg && (top < maxw_reg)) ? top : maxw_reg;

    assign status.scan_op   = mode[1];
    assign status.scan_last = (scan_cnt_reg == LAST_IDX);
    assign status.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            now_reg  <= now_time;
            maxw_reg <= wait_cap;
        end
        rd_idx_reg <= scan_cnt_reg;
        if (cmd.capture || take)
        begin
            best_idx_reg <= rd_idx_reg;
            best_dl_reg  <= ram_rdata;
        end
        if (cmd.load)
        begin
            case (mode_reg)
                MODE_DISPATCH:
                begin
                    fired_reg    <= due;
                    fired_id_reg <= due ? FID_W'(best_idx_reg) : '0;
                    wait_reg     <= '0;
                end
                MODE_WAIT:
                begin
                    fired_reg    <= 1'b0;
                    fired_id_reg <= '0;
                    wait_reg     <= wait_val;
                end
                default:
                begin
                    fired_reg    <= 1'b0;
                    fired_id_reg <= '0;
                    wait_reg     <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg      <= '0;
            scan_cnt_reg   <= '0;
            rd_valid_reg   <= 1'b0;
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan_en;
            if (cmd.capture)
            begin
                scan_cnt_reg   <= '0;
                best_valid_reg <= 1'b0;
                if (!mode[1] && id_ok)
                begin
                    armed_reg[id_idx] <= arm_new;
                end
            end
            else
            begin
                if (cmd.scan_en)
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
                if (take)
                begin
                    best_valid_reg <= 1'b1;
                end
            end
            // dispatch disarms the timer it reports
            if (cmd.load && (mode_reg == MODE_DISPATCH) && due)
            begin
                armed_reg[best_idx_reg] <= 1'b0;
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign fired         = fired_reg;
    assign fired_id      = fired_id_reg;
    assign wait_interval = wait_reg;

endmodule

/* hdl/earliest_deadline_timer_set.sv */
// Top level of the earliest-deadline timer set: controller plus datapath.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one command beat: mode selects
//   set, unset, dispatch or wait; timer_id, expiry_time, now_time and
//   wait_cap are its operands. Every input beat yields exactly one result
//   beat on the output channel (out_valid/out_ready): fired, fired_id and
//   wait_interval, zero where the mode does not produce them.
//   Set and unset update the timer state when the beat is taken and pass
//   through the finishing state to the output register. Dispatch and wait
//   scan every timer entry through the single read port of the deadline
//   RAM, one entry per cycle, then pass through the evaluate state to the
//   finishing state. in_ready rises together with out_valid. One command
//   is in flight at a time.
//   The result sits in an output register: if the receiver stalls, it is
//   held stable; the next command is still taken and runs, then waits in
//   the finishing state until the register is taken.
//   Reset (rst_n low, asynchronous) disarms every timer and empties the
//   output register. Deadline storage is not cleared; an entry is only
//   used while its timer is armed, and arming always writes it.
module earliest_deadline_timer_set (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  etds_pkg::mode_t                   mode,
    input  logic [3:0]                        timer_id,
    input  logic signed [etds_pkg::TIME_W-1:0] expiry_time,
    input  logic [etds_pkg::DL_W-1:0]         now_time,
    input  logic signed [etds_pkg::TIME_W-1:0] wait_cap,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              fired,
    output logic [etds_pkg::FID_W-1:0]        fired_id,
    output logic signed [etds_pkg::TIME_W-1:0] wait_interval
);
    import etds_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // sequencer: idle -> (scan -> eval ->) finish -> idle
    etds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // timer state, min search and result register
    etds_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .mode          (mode),
        .timer_id      (timer_id),
        .expiry_time   (expiry_time),
        .now_time      (now_time),
        .wait_cap      (wait_cap),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .fired         (fired),
        .fired_id      (fired_id),
        .wait_interval (wait_interval)
    );

endmodule

/* hdl/etds_checker.sv */
// Port-level checker for the earliest-deadline timer set, bound to the top level.
module etds_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic                              fired,
    input logic [etds_pkg::FID_W-1:0]        fired_id,
    input logic signed [etds_pkg::TIME_W-1:0] wait_interval
);
    import etds_pkg::*;

    // a fired dispatch never carries a wait value
    a_fired_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fired |-> wait_interval == '0)
        else $error("fired result with nonzero wait_interval");

    // no timer number without a fire
    a_idle_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !fired |-> fired_id == '0)
        else $error("fired_id nonzero while fired is low");

    // one command at a time: a taken beat drops in_ready
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready stayed high after an input beat");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(fired)
            && $stable(fired_id) && $stable(wait_interval))
        else $error("output beat changed while stalled");

endmodule

bind earliest_deadline_timer_set etds_checker u_etds_checker (.*);

/* bench/earliest_deadline_timer_set_tb.sv */
// Self-checking bench for the earliest-deadline timer set: directed and random command traffic.
`timescale 1ns / 1ps

module earliest_deadline_timer_set_tb;

    import etds_pkg::*;

    localparam int        CLK_HALF     = 4;      // 8 ns period
    localparam int        RESET_CYCLES = 11;
    localparam int        RANDOM_ITEMS = 1600;
    localparam int        IDLE_LIMIT   = 1000;   // cycles with no beat on either side
    localparam int        SETTLE_CYCLES = 40;    // longer than one unstalled dispatch or wait
    localparam logic [63:0] DL_MASK    = (64'd1 << DL_W) - 64'd1;
    localparam logic [63:0] TIME_MASK  = (64'd1 << TIME_W) - 64'd1;
    localparam longint    DL_MAX       = (64'sd1 <<< DL_W) - 64'sd1;

    // One result beat.
    typedef struct {
        logic                     fired;
        logic [FID_W-1:0]         fired_id;
        logic signed [TIME_W-1:0] wait_interval;
    } outcome_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Input channel
    logic                     in_valid    = 1'b0;
    logic                     in_ready;
    mode_t                    mode        = MODE_SET;
    logic [3:0]               timer_id    = '0;
    logic signed [TIME_W-1:0] expiry_time = '0;
    logic [DL_W-1:0]          now_time    = '0;
    logic signed [TIME_W-1:0] wait_cap    = '0;

    // Output channel
    logic                     out_valid;
    logic                     out_ready   = 1'b0;
    logic                     fired;
    logic [FID_W-1:0]         fired_id;
    logic signed [TIME_W-1:0] wait_interval;

    // Shadow copy of the timer state, updated as each command beat is taken.
    logic                     shadow_armed    [TIMER_COUNT];
    logic [DL_W-1:0]          shadow_deadline [TIMER_COUNT];

    outcome_t pending_outcomes[$];
    int       error_count = 0;
    int       idle_cycles = 0;

    // Sender burst shaping state.
    int       burst_left = 0;
    // Running notion of "now" for well-formed random traffic.
    longint   sim_now = 0;

    earliest_deadline_timer_set DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .timer_id      (timer_id),
        .expiry_time   (expiry_time),
        .now_time      (now_time),
        .wait_cap      (wait_cap),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .fired         (fired),
        .fired_id      (fired_id),
        .wait_interval (wait_interval)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction. Applies one command to the shadow state and returns the
    // result beat it must produce. Earliest armed timer wins; ties go to
    // the lowest timer number because only a strictly smaller deadline
    // replaces the current pick.
    // ------------------------------------------------------------------
    function automatic outcome_t compute_outcome(mode_t m, logic [3:0] id,
                                                 logic signed [TIME_W-1:0] expiry,
                                                 logic [DL_W-1:0] now,
                                                 logic signed [TIME_W-1:0] limit);
        outcome_t res;
        int       best;
        longint   span;
        longint   shortest;
        res.fired         = 1'b0;
        res.fired_id      = '0;
        res.wait_interval = '0;
        best = -1;
        for (int i = 0; i < TIMER_COUNT; i++)
        begin
            if (shadow_armed[i] && (best < 0 || shadow_deadline[i] < shadow_deadline[best]))
                best = i;
        end
        case (m)
            MODE_SET, MODE_UNSET:
            begin
                // ids beyond TIMER_COUNT would be ignored; 4 bits never exceed 16
                if (int'(id) < TIMER_COUNT)
                begin
                    if (m == MODE_SET && !expiry[TIME_W-1])
                    begin
                        shadow_deadline[id] = expiry[DL_W-1:0];
                        shadow_armed[id]    = 1'b1;
                    end
                    else
                        shadow_armed[id] = 1'b0;
                end
            end
            MODE_DISPATCH:
            begin
                if (best >= 0 && shadow_deadline[best] <= now)
                begin
                    shadow_armed[best] = 1'b0;
                    res.fired          = 1'b1;
                    res.fired_id       = best[FID_W-1:0];
                end
            end
            default:
            begin
                // full 48-bit wait cap, min taken exactly in 64-bit arithmetic
                shortest = longint'(limit);
                if (best >= 0)
                begin
                    span = longint'({17'd0, shadow_deadline[best]}) - longint'({17'd0, now});
                    if (span < shortest)
                        shortest = span;
                end
                res.wait_interval = shortest[TIME_W-1:0];
            end
        endcase
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // ------------------------------------------------------------------
    // Sender: drives one command beat at the falling edge and holds it
    // until it is taken. The outcome is predicted at the accepting edge so
    // the shadow state follows the block in beat order.
    // ------------------------------------------------------------------
    task automatic send_command(mode_t m, logic [3:0] id,
                                logic signed [TIME_W-1:0] expiry,
                                logic [DL_W-1:0] now,
                                logic signed [TIME_W-1:0] limit);
        @(negedge clk);
        in_valid    <= 1'b1;
        mode        <= m;
        timer_id    <= id;
        expiry_time <= expiry;
        now_time    <= now;
        wait_cap    <= limit;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        pending_outcomes.push_back(compute_outcome(m, id, expiry, now, limit));
    endtask

    // Drop valid for a number of cycles.
    task automatic idle_sender(int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    // Hold off the sender until every outstanding result beat has come back.
    task automatic wait_all_outcomes();
        idle_sender(1);
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // Burst/gap shaping between random beats. Long bursts give stretches
    // with no sender idling at all.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(1, 12);
            idle_sender(gap);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver stall pattern: a repeating round of four phases - always
    // ready, coin flip, long stall runs, and a fixed one-in-three stall.
    // ------------------------------------------------------------------
    logic [9:0] stall_clock = '0;
    int         stall_run   = 0;

    always @(negedge clk)
    begin
        case (stall_clock[9:8])
            2'd0: out_ready <= 1'b1;
            2'd1: out_ready <= 1'($urandom_range(0, 1));
            2'd2:
            begin
                if (stall_run > 0)
                begin
                    stall_run = stall_run - 1;
                    out_ready <= 1'b0;
                end
                else
                begin
                    out_ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        stall_run = $urandom_range(1, 25);
                end
            end
            default: out_ready <= (stall_clock % 3 != 0);
        endcase
        stall_clock = stall_clock + 1'b1;
    end

    // ------------------------------------------------------------------
    // Result checker: every result beat is matched against the oldest
    // prediction, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result beat fired=%0b id=%0d wait=%0d",
                         $realtime, fired, fired_id, wait_interval);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (fired !== want.fired)
                begin
                    error_count++;
                    $display("%0t: fired mismatch expected %0b actual %0b",
                             $realtime, want.fired, fired);
                end
                if (fired_id !== want.fired_id)
                begin
                    error_count++;
                    $display("%0t: fired_id mismatch expected %0d actual %0d",
                             $realtime, want.fired_id, fired_id);
                end
                if (wait_interval !== want.wait_interval)
                begin
                    error_count++;
                    $display("%0t: wait_interval mismatch expected %0d actual %0d",
                             $realtime, want.wait_interval, wait_interval);
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves a beat.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[earliest_deadline_timer_set] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Nothing armed: wait returns the cap at both extremes (including the
    // 48-bit minimum outside the nominal range), dispatch fires nothing,
    // unset of an idle timer is harmless.
    task automatic test_empty_set();
        send_command(MODE_WAIT,     4'd0, '0, '0, DL_MAX[TIME_W-1:0]);
        send_command(MODE_WAIT,     4'd0, '0, '1, 48'sh8000_0000_0000);
        send_command(MODE_DISPATCH, 4'd0, '0, '1, '0);
        send_command(MODE_UNSET,    4'd7, '0, '0, '0);
    endtask

    // Deadline extremes, dispatch with nothing due, and firing at the bound.
    task automatic test_arm_and_fire();
        send_command(MODE_SET,      4'd0,  48'sd0,             '0, '0);
        send_command(MODE_SET,      4'd15, DL_MAX[TIME_W-1:0], '0, '0);
        send_command(MODE_WAIT,     4'd0,  '0, '0, DL_MAX[TIME_W-1:0]);
        send_command(MODE_DISPATCH, 4'd0,  '0, '0, '0);
        send_command(MODE_WAIT,     4'd0,  '0, '0, DL_MAX[TIME_W-1:0]);
        send_command(MODE_DISPATCH, 4'd0,  '0, DL_MAX[DL_W-1:0] - 1'b1, '0);
        send_command(MODE_DISPATCH, 4'd0,  '0, DL_MAX[DL_W-1:0], '0);
    endtask

    // Equal deadlines go to the lowest number; negative expiry disarms;
    // re-arming only moves the deadline.
    task automatic test_ties_and_rearm();
        send_command(MODE_SET,      4'd3,  48'sd100, '0, '0);
        send_command(MODE_SET,      4'd5,  48'sd100, '0, '0);
        send_command(MODE_SET,      4'd9,  48'sd100, '0, '0);
        send_command(MODE_SET,      4'd3,  -48'sd1,  '0, '0);
        send_command(MODE_SET,      4'd5,  48'sd200, '0, '0);
        send_command(MODE_WAIT,     4'd0,  '0, '0, DL_MAX[TIME_W-1:0]);
        send_command(MODE_WAIT,     4'd0,  '0, DL_MAX[DL_W-1:0], -DL_MAX[TIME_W-1:0]);
        send_command(MODE_DISPATCH, 4'd0,  '0, 47'd1000, '0);
        send_command(MODE_SET,      4'd9,  48'sh8000_0000_0000, '0, '0);
        send_command(MODE_UNSET,    4'd5,  '0, '0, '0);
        send_command(MODE_SET,      4'd12, 48'sd50, '0, '0);
        send_command(MODE_SET,      4'd2,  48'sd50, '0, '0);
        send_command(MODE_DISPATCH, 4'd0,  '0, 47'd50, '0);
        send_command(MODE_DISPATCH, 4'd0,  '0, 47'd50, '0);
    endtask

    // Random traffic, mostly timers armed just ahead of a moving "now" so
    // dispatch and wait see real contention; the rest is full-range noise.
    task automatic test_random_traffic();
        int                       pick;
        mode_t                    m;
        logic [3:0]               id;
        logic signed [TIME_W-1:0] expiry;
        logic [DL_W-1:0]          now;
        logic signed [TIME_W-1:0] limit;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // occasionally relocate the time base to exercise high bits
            if ($urandom_range(0, 99) == 0)
                sim_now = longint'(rand64() & DL_MASK) % (DL_MAX - 5000);
            sim_now += $urandom_range(0, 8);
            id     = 4'($urandom_range(0, 15));
            expiry = '0;
            now    = sim_now[DL_W-1:0];
            limit  = '0;
            pick   = $urandom_range(0, 99);
            if (pick < 40)
            begin
                m    = MODE_SET;
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    expiry = TIME_W'(sim_now + $urandom_range(0, 80) - 10);
                else if (pick < 85)
                    expiry = TIME_W'((rand64() & TIME_MASK) | (64'd1 << (TIME_W - 1)));
                else
                    expiry = TIME_W'(rand64() & TIME_MASK);
            end
            else if (pick < 50)
                m = MODE_UNSET;
            else if (pick < 78)
            begin
                m = MODE_DISPATCH;
                if ($urandom_range(0, 9) == 0)
                    now = DL_W'(rand64() & DL_MASK);
            end
            else
            begin
                m = MODE_WAIT;
                if ($urandom_range(0, 9) == 0)
                    now = DL_W'(rand64() & DL_MASK);
                if ($urandom_range(0, 1) == 0)
                    limit = TIME_W'(longint'($urandom_range(0, 1100)) - 100);
                else
                    limit = TIME_W'(rand64() & TIME_MASK);
            end
            // noise fields carry random junk in modes that ignore them
            if (m != MODE_SET && $urandom_range(0, 3) == 0)
                expiry = TIME_W'(rand64() & TIME_MASK);
            send_command(m, id, expiry, now, limit);
            if (n % 400 == 399)
                wait_all_outcomes();
            else
                pace_sender();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < TIMER_COUNT; i++)
        begin
            shadow_armed[i]    = 1'b0;
            shadow_deadline[i] = '0;
        end
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_set();
        test_arm_and_fire();
        test_ties_and_rearm();
        wait_all_outcomes();
        test_random_traffic();

        idle_sender(1);
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("[earliest_deadline_timer_set] OK");
        else
            $display("[earliest_deadline_timer_set] ERROR");
        $finish;
    end

endmodule
